FILE: hdl/assert_macros.svh
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, ignored while reset is applied.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check a property on every rising clock edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/pit_pkg.sv
package pit_pkg;

	// Default coordinate width in bits.
	localparam int COORD_WIDTH_DEF = 16;

	// Register stages from an accepted input to the result register.
	localparam int PIPE_DEPTH = 8;

endpackage

FILE: hdl/pit_cross.sv
module pit_cross #(
	parameter int IN_WIDTH = pit_pkg::COORD_WIDTH_DEF + 1
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [IN_WIDTH-1:0]  a_x,
	input  logic signed [IN_WIDTH-1:0]  a_y,
	input  logic signed [IN_WIDTH-1:0]  a_z,
	input  logic signed [IN_WIDTH-1:0]  b_x,
	input  logic signed [IN_WIDTH-1:0]  b_y,
	input  logic signed [IN_WIDTH-1:0]  b_z,
	output logic signed [2*IN_WIDTH:0]  c_x,
	output logic signed [2*IN_WIDTH:0]  c_y,
	output logic signed [2*IN_WIDTH:0]  c_z
);

	localparam int PW = 2 * IN_WIDTH;
	localparam int CW = 2 * IN_WIDTH + 1;

	logic signed [PW-1:0] yz_s2, zy_s2, zx_s2, xz_s2, xy_s2, yx_s2;
	logic signed [CW-1:0] cx_s3, cy_s3, cz_s3;

	// Form the six component products
	always_ff @(posedge clk) begin
		if (en) begin
			yz_s2 <= a_y * b_z;
			zy_s2 <= a_z * b_y;
			zx_s2 <= a_z * b_x;
			xz_s2 <= a_x * b_z;
			xy_s2 <= a_x * b_y;
			yx_s2 <= a_y * b_x;
		end
	end

	// Subtract product pairs into cross components
	always_ff @(posedge clk) begin
		if (en) begin
			cx_s3 <= CW'(yz_s2) - CW'(zy_s2);
			cy_s3 <= CW'(zx_s2) - CW'(xz_s2);
			cz_s3 <= CW'(xy_s2) - CW'(yx_s2);
		end
	end

	assign c_x = cx_s3;
	assign c_y = cy_s3;
	assign c_z = cz_s3;

endmodule

FILE: hdl/pit_dot.sv
module pit_dot #(
	parameter int CW = 2 * (pit_pkg::COORD_WIDTH_DEF + 1) + 1
) (
	input  logic                  clk,
	input  logic                  en,
	input  logic signed [CW-1:0]  a_x,
	input  logic signed [CW-1:0]  a_y,
	input  logic signed [CW-1:0]  a_z,
	input  logic signed [CW-1:0]  b_x,
	input  logic signed [CW-1:0]  b_y,
	input  logic signed [CW-1:0]  b_z,
	output logic                  nonneg
);

	// Each operand splits into a signed upper half and an unsigned lower half
	localparam int LW = (CW + 1) / 2;
	localparam int HW = CW - LW;
	localparam int TW = 2 * CW + 2;

	logic signed [HW-1:0] ah_x, ah_y, ah_z, bh_x, bh_y, bh_z;
	logic signed [LW:0]   al_x, al_y, al_z, bl_x, bl_y, bl_z;

	logic signed [2*HW-1:0]  hh_x_s4, hh_y_s4, hh_z_s4;
	logic signed [HW+LW:0]   hl_x_s4, hl_y_s4, hl_z_s4;
	logic signed [HW+LW:0]   lh_x_s4, lh_y_s4, lh_z_s4;
	logic signed [2*LW+1:0]  ll_x_s4, ll_y_s4, ll_z_s4;

	logic signed [TW-1:0] hh_s5, hl_s5, lh_s5, ll_s5;
	logic signed [TW-1:0] hi_s6, lo_s6;
	logic                 nonneg_s7;

	// Split operands
	assign ah_x = a_x[CW-1:LW];
	assign ah_y = a_y[CW-1:LW];
	assign ah_z = a_z[CW-1:LW];
	assign bh_x = b_x[CW-1:LW];
	assign bh_y = b_y[CW-1:LW];
	assign bh_z = b_z[CW-1:LW];
	assign al_x = {1'b0, a_x[LW-1:0]};
	assign al_y = {1'b0, a_y[LW-1:0]};
	assign al_z = {1'b0, a_z[LW-1:0]};
	assign bl_x = {1'b0, b_x[LW-1:0]};
	assign bl_y = {1'b0, b_y[LW-1:0]};
	assign bl_z = {1'b0, b_z[LW-1:0]};

	// Form the partial products of each component
	always_ff @(posedge clk) begin
		if (en) begin
			hh_x_s4 <= ah_x * bh_x;
			hh_y_s4 <= ah_y * bh_y;
			hh_z_s4 <= ah_z * bh_z;
			hl_x_s4 <= ah_x * bl_x;
			hl_y_s4 <= ah_y * bl_y;
			hl_z_s4 <= ah_z * bl_z;
			lh_x_s4 <= al_x * bh_x;
			lh_y_s4 <= al_y * bh_y;
			lh_z_s4 <= al_z * bh_z;
			ll_x_s4 <= al_x * bl_x;
			ll_y_s4 <= al_y * bl_y;
			ll_z_s4 <= al_z * bl_z;
		end
	end

	// Sum partial products of equal weight across components
	always_ff @(posedge clk) begin
		if (en) begin
			hh_s5 <= TW'(hh_x_s4) + TW'(hh_y_s4) + TW'(hh_z_s4);
			hl_s5 <= TW'(hl_x_s4) + TW'(hl_y_s4) + TW'(hl_z_s4);
			lh_s5 <= TW'(lh_x_s4) + TW'(lh_y_s4) + TW'(lh_z_s4);
			ll_s5 <= TW'(ll_x_s4) + TW'(ll_y_s4) + TW'(ll_z_s4);
		end
	end

	// Fold the upper weights together
	always_ff @(posedge clk) begin
		if (en) begin
			hi_s6 <= (hh_s5 <<< LW) + hl_s5 + lh_s5;
			lo_s6 <= ll_s5;
		end
	end

	// Take the sign of the full dot product
	always_ff @(posedge clk) begin
		if (en) begin
			nonneg_s7 <= ~(TW'((hi_s6 <<< LW) + lo_s6) < 0);
		end
	end

	assign nonneg = nonneg_s7;

endmodule

FILE: hdl/pit_edge.sv
module pit_edge #(
	parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [COORD_WIDTH:0] e_x,
	input  logic signed [COORD_WIDTH:0] e_y,
	input  logic signed [COORD_WIDTH:0] e_z,
	input  logic signed [COORD_WIDTH:0] p_x,
	input  logic signed [COORD_WIDTH:0] p_y,
	input  logic signed [COORD_WIDTH:0] p_z,
	input  logic signed [COORD_WIDTH:0] w_x,
	input  logic signed [COORD_WIDTH:0] w_y,
	input  logic signed [COORD_WIDTH:0] w_z,
	output logic                        pass
);

	localparam int DW = COORD_WIDTH + 1;
	localparam int CW = 2 * DW + 1;

	logic signed [CW-1:0] c1_x, c1_y, c1_z;
	logic signed [CW-1:0] c2_x, c2_y, c2_z;

	// Edge crossed with the point offset
	pit_cross #(.IN_WIDTH(DW)) u_cross_point (
		.clk (clk), .en (en),
		.a_x (e_x), .a_y (e_y), .a_z (e_z),
		.b_x (p_x), .b_y (p_y), .b_z (p_z),
		.c_x (c1_x), .c_y (c1_y), .c_z (c1_z)
	);

	// Edge crossed with the opposite vertex offset
	pit_cross #(.IN_WIDTH(DW)) u_cross_vertex (
		.clk (clk), .en (en),
		.a_x (e_x), .a_y (e_y), .a_z (e_z),
		.b_x (w_x), .b_y (w_y), .b_z (w_z),
		.c_x (c2_x), .c_y (c2_y), .c_z (c2_z)
	);

	// Same side when the dot product is not negative
	pit_dot #(.CW(CW)) u_dot (
		.clk    (clk),
		.en     (en),
		.a_x    (c1_x), .a_y (c1_y), .a_z (c1_z),
		.b_x    (c2_x), .b_y (c2_y), .b_z (c2_z),
		.nonneg (pass)
	);

endmodule

FILE: hdl/point_in_triangle_test.sv
// Channel  | Direction | Handshake           | Payload
// input    | in        | in_valid, in_stall  | point_*, first_*, second_*, third_*
// output   | out       | out_valid, out_stall| inside_res
//
// One query enters per cycle while in_stall is low; each result passes through eight
// register stages before it shows on the output:
// differences, products, cross components, partial products, sums, fold, sign, final AND.
// Reset clears only the stage valid bits; data registers are not reset.
// A stalled result freezes the whole pipeline, and in_stall follows at once.
module point_in_triangle_test #(
	parameter int COORD_WIDTH = pit_pkg::COORD_WIDTH_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic signed [COORD_WIDTH-1:0] point_x,
	input  logic signed [COORD_WIDTH-1:0] point_y,
	input  logic signed [COORD_WIDTH-1:0] point_z,
	input  logic signed [COORD_WIDTH-1:0] first_x,
	input  logic signed [COORD_WIDTH-1:0] first_y,
	input  logic signed [COORD_WIDTH-1:0] first_z,
	input  logic signed [COORD_WIDTH-1:0] second_x,
	input  logic signed [COORD_WIDTH-1:0] second_y,
	input  logic signed [COORD_WIDTH-1:0] second_z,
	input  logic signed [COORD_WIDTH-1:0] third_x,
	input  logic signed [COORD_WIDTH-1:0] third_y,
	input  logic signed [COORD_WIDTH-1:0] third_z,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic                          inside_res
);

	import pit_pkg::*;

	localparam int DW = COORD_WIDTH + 1;

	logic                  en;
	logic [PIPE_DEPTH-1:0] valid_pipe_q;

	logic signed [DW-1:0] cmb_x_s1, cmb_y_s1, cmb_z_s1;
	logic signed [DW-1:0] pmb_x_s1, pmb_y_s1, pmb_z_s1;
	logic signed [DW-1:0] amb_x_s1, amb_y_s1, amb_z_s1;
	logic signed [DW-1:0] cma_x_s1, cma_y_s1, cma_z_s1;
	logic signed [DW-1:0] pma_x_s1, pma_y_s1, pma_z_s1;
	logic signed [DW-1:0] bma_x_s1, bma_y_s1, bma_z_s1;

	logic pass_bc, pass_ac, pass_ab;
	logic inside_s8;

	// Advance everything unless the result is held by the receiver
	assign en       = ~out_valid | ~out_stall;
	assign in_stall = ~en;

	// Shift the valid bits along with the data
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_pipe_q <= '0;
		end else if (en) begin
			valid_pipe_q <= {valid_pipe_q[PIPE_DEPTH-2:0], in_valid};
		end
	end

	// Vertex and point offsets
	always_ff @(posedge clk) begin
		if (en) begin
			cmb_x_s1 <= DW'(third_x) - DW'(second_x);
			cmb_y_s1 <= DW'(third_y) - DW'(second_y);
			cmb_z_s1 <= DW'(third_z) - DW'(second_z);
			pmb_x_s1 <= DW'(point_x) - DW'(second_x);
			pmb_y_s1 <= DW'(point_y) - DW'(second_y);
			pmb_z_s1 <= DW'(point_z) - DW'(second_z);
			amb_x_s1 <= DW'(first_x) - DW'(second_x);
			amb_y_s1 <= DW'(first_y) - DW'(second_y);
			amb_z_s1 <= DW'(first_z) - DW'(second_z);
			cma_x_s1 <= DW'(third_x) - DW'(first_x);
			cma_y_s1 <= DW'(third_y) - DW'(first_y);
			cma_z_s1 <= DW'(third_z) - DW'(first_z);
			pma_x_s1 <= DW'(point_x) - DW'(first_x);
			pma_y_s1 <= DW'(point_y) - DW'(first_y);
			pma_z_s1 <= DW'(point_z) - DW'(first_z);
			bma_x_s1 <= DW'(second_x) - DW'(first_x);
			bma_y_s1 <= DW'(second_y) - DW'(first_y);
			bma_z_s1 <= DW'(second_z) - DW'(first_z);
		end
	end

	// Edge from second to third vertex, against the first
	pit_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_bc (
		.clk (clk), .en (en),
		.e_x (cmb_x_s1), .e_y (cmb_y_s1), .e_z (cmb_z_s1),
		.p_x (pmb_x_s1), .p_y (pmb_y_s1), .p_z (pmb_z_s1),
		.w_x (amb_x_s1), .w_y (amb_y_s1), .w_z (amb_z_s1),
		.pass (pass_bc)
	);

	// Edge from first to third vertex, against the second
	pit_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_ac (
		.clk (clk), .en (en),
		.e_x (cma_x_s1), .e_y (cma_y_s1), .e_z (cma_z_s1),
		.p_x (pma_x_s1), .p_y (pma_y_s1), .p_z (pma_z_s1),
		.w_x (bma_x_s1), .w_y (bma_y_s1), .w_z (bma_z_s1),
		.pass (pass_ac)
	);

	// Edge from first to second vertex, against the third
	pit_edge #(.COORD_WIDTH(COORD_WIDTH)) u_edge_ab (
		.clk (clk), .en (en),
		.e_x (bma_x_s1), .e_y (bma_y_s1), .e_z (bma_z_s1),
		.p_x (pma_x_s1), .p_y (pma_y_s1), .p_z (pma_z_s1),
		.w_x (cma_x_s1), .w_y (cma_y_s1), .w_z (cma_z_s1),
		.pass (pass_ab)
	);

	// AND the edge tests bc, ac and ab into the result register
	always_ff @(posedge clk) begin
		if (en) begin
			inside_s8 <= pass_bc & pass_ac & pass_ab;
		end
	end

	assign out_valid  = valid_pipe_q[PIPE_DEPTH-1];
	assign inside_res = inside_s8;

endmodule

FILE: hdl/pit_check.sv
`include "assert_macros.svh"

module pit_check (
	input logic clk,
	input logic arst_n,
	input logic in_stall,
	input logic out_valid,
	input logic out_stall,
	input logic inside_res
);

	// Input backs up exactly when a result is held
	`ASSERT_CLK(a_stall_link, in_stall == (out_valid && out_stall), "in_stall does not track held result")

	// A held result keeps its value
	`ASSERT_CLK(a_hold_result, out_valid && out_stall |=> out_valid && $stable(inside_res), "held result changed")

	// No result right after reset
	`ASSERT_ALWAYS(a_reset_empty, !arst_n |=> !out_valid, "result valid after reset")

	// Input is never backed up while no result is pending
	`ASSERT_CLK(a_free_flow, !out_valid |-> !in_stall, "input stalled with empty output")

endmodule

bind point_in_triangle_test pit_check u_pit_check (.*);

FILE: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

	localparam int COORD_W = pit_pkg::COORD_WIDTH_DEF;
	localparam int TAIL_CYCLES = pit_pkg::PIPE_DEPTH + 20;
	localparam int RANDOM_QUERIES = 1000;
	localparam int unsigned CYCLE_LIMIT = 600000;

	typedef logic signed [COORD_W-1:0] coord_t;
	typedef logic signed [127:0] wide_t;

	typedef struct {
		coord_t x, y, z;
	} pt_t;

	typedef struct {
		pt_t p, a, b, c;
		bit  hold_off;
	} query_t;

	typedef struct {
		longint x, y, z;
	} vec3_t;

	logic   clk = 1'b0;
	logic   arst_n = 1'b0;
	logic   in_valid = 1'b0;
	logic   in_stall;
	coord_t point_x = '0, point_y = '0, point_z = '0;
	coord_t first_x = '0, first_y = '0, first_z = '0;
	coord_t second_x = '0, second_y = '0, second_z = '0;
	coord_t third_x = '0, third_y = '0, third_z = '0;
	logic   out_valid;
	logic   out_stall = 1'b0;
	logic   inside_res;

	query_t      query_queue[$];
	bit          inside_expected[$];
	query_t      cur_query;
	int unsigned gap_left = 0;
	int unsigned stall_left = 0;
	int unsigned mismatch_count = 0;
	bit [31:0]   cycle_count = '0;
	bit          want;
	wire         quiet = (cycle_count[10:9] == 2'b01);

	point_in_triangle_test u_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.point_x    (point_x),
		.point_y    (point_y),
		.point_z    (point_z),
		.first_x    (first_x),
		.first_y    (first_y),
		.first_z    (first_z),
		.second_x   (second_x),
		.second_y   (second_y),
		.second_z   (second_z),
		.third_x    (third_x),
		.third_y    (third_y),
		.third_z    (third_z),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.inside_res (inside_res)
	);

	// Exact same-side prediction at full width
	function automatic vec3_t to_vec(pt_t q);
		vec3_t v;
		v.x = q.x;
		v.y = q.y;
		v.z = q.z;
		return v;
	endfunction

	function automatic vec3_t sub3(vec3_t a, vec3_t b);
		vec3_t r;
		r.x = a.x - b.x;
		r.y = a.y - b.y;
		r.z = a.z - b.z;
		return r;
	endfunction

	function automatic vec3_t cross3(vec3_t a, vec3_t b);
		vec3_t r;
		r.x = a.y * b.z - a.z * b.y;
		r.y = a.z * b.x - a.x * b.z;
		r.z = a.x * b.y - a.y * b.x;
		return r;
	endfunction

	// Pass when P and W fall on the same side of edge U-V, or on it
	function automatic bit side_ok(vec3_t p, vec3_t u, vec3_t v, vec3_t w);
		vec3_t e, c1, c2;
		wide_t s;
		e  = sub3(v, u);
		c1 = cross3(e, sub3(p, u));
		c2 = cross3(e, sub3(w, u));
		s  = wide_t'(c1.x) * wide_t'(c2.x) + wide_t'(c1.y) * wide_t'(c2.y)
		   + wide_t'(c1.z) * wide_t'(c2.z);
		return !s[127];
	endfunction

	function automatic bit predict_inside(query_t q);
		vec3_t p, a, b, c;
		p = to_vec(q.p);
		a = to_vec(q.a);
		b = to_vec(q.b);
		c = to_vec(q.c);
		return side_ok(p, b, c, a) && side_ok(p, a, c, b) && side_ok(p, a, b, c);
	endfunction

	// Stimulus helpers
	function automatic int srand(int lo, int hi);
		return int'($urandom_range(hi - lo)) + lo;
	endfunction

	function automatic coord_t clamp_coord(longint v);
		if (v > 32767)
			return coord_t'(32767);
		if (v < -32768)
			return coord_t'(-32768);
		return coord_t'(v);
	endfunction

	function automatic pt_t mk_pt(longint x, longint y, longint z);
		pt_t q;
		q.x = clamp_coord(x);
		q.y = clamp_coord(y);
		q.z = clamp_coord(z);
		return q;
	endfunction

	// Mostly full range, sometimes an extreme or a value near zero
	function automatic int rand_wide();
		case ($urandom_range(9))
			0:       return -32768;
			1:       return 32767;
			2, 3:    return srand(-8, 8);
			default: return srand(-32768, 32767);
		endcase
	endfunction

	function automatic pt_t rand_pt();
		return mk_pt(rand_wide(), rand_wide(), rand_wide());
	endfunction

	function automatic coord_t blend(coord_t ua, coord_t ub, coord_t uc,
	                                 int wa, int wb, int wc);
		longint acc;
		acc = (longint'(ua) * wa + longint'(ub) * wb + longint'(uc) * wc) / (wa + wb + wc);
		if ($urandom_range(1) == 1)
			acc = acc + srand(-2, 2);
		return clamp_coord(acc);
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		return $urandom_range(30, 4);
	endfunction

	function automatic query_t make_random_query();
		query_t q;
		pt_t    a, b, c, p, t;
		int     kind, wa, wb, wc, m, n, k, dx, dy, dz;
		kind = $urandom_range(99);
		a = rand_pt();
		b = rand_pt();
		c = rand_pt();
		p = rand_pt();
		dx = srand(-64, 64);
		dy = srand(-64, 64);
		dz = srand(-64, 64);
		m  = srand(1, 200);
		n  = srand(-200, 200);
		k  = srand(0, m);
		if (kind < 40) begin
			// point blended from the vertices, with a little noise
			wa = srand(0, 15);
			wb = srand(0, 15);
			wc = srand(1, 15);
			p.x = blend(a.x, b.x, c.x, wa, wb, wc);
			p.y = blend(a.y, b.y, c.y, wa, wb, wc);
			p.z = blend(a.z, b.z, c.z, wa, wb, wc);
		end else if (kind < 60) begin
			// point exactly on one edge, roles shuffled
			a = mk_pt(srand(-16384, 16383), srand(-16384, 16383), srand(-16384, 16383));
			b = mk_pt(a.x + m * dx, a.y + m * dy, a.z + m * dz);
			p = mk_pt(a.x + k * dx, a.y + k * dy, a.z + k * dz);
			if ($urandom_range(1) == 1) begin
				t = a; a = c; c = t;
			end
			if ($urandom_range(1) == 1) begin
				t = b; b = c; c = t;
			end
		end else if (kind < 70) begin
			// collinear vertices, point on the line or anywhere
			a = mk_pt(srand(-16384, 16383), srand(-16384, 16383), srand(-16384, 16383));
			b = mk_pt(a.x + m * dx, a.y + m * dy, a.z + m * dz);
			c = mk_pt(a.x + n * dx, a.y + n * dy, a.z + n * dz);
			if ($urandom_range(1) == 1)
				p = mk_pt(a.x + k * dx, a.y + k * dy, a.z + k * dz);
		end else if (kind < 82) begin
			// tiny grid, many points on edges and vertices
			a = mk_pt(srand(-6, 6), srand(-6, 6), srand(-2, 2));
			b = mk_pt(srand(-6, 6), srand(-6, 6), srand(-2, 2));
			c = mk_pt(srand(-6, 6), srand(-6, 6), srand(-2, 2));
			p = mk_pt(srand(-6, 6), srand(-6, 6), srand(-2, 2));
		end
		q.p = p;
		q.a = a;
		q.b = b;
		q.c = c;
		q.hold_off = 1'b0;
		return q;
	endfunction

	task automatic add_query(pt_t p, pt_t a, pt_t b, pt_t c);
		query_t q;
		q.p = p;
		q.a = a;
		q.b = b;
		q.c = c;
		q.hold_off = 1'b0;
		query_queue.push_back(q);
	endtask

	task automatic report_mismatch(string what, bit got, bit exp_val);
		$display("cycle %0d: %s: inside_res %0d, expected %0d", cycle_count, what, got, exp_val);
		mismatch_count++;
	endtask

	// Clock
	initial begin
		forever #1 clk = ~clk;
	end

	// Drive queries; hold the payload while stalled
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
			gap_left = 0;
		end else if (!(in_valid && in_stall)) begin
			if (in_valid)
				inside_expected.push_back(predict_inside(cur_query));
			if (gap_left != 0) begin
				gap_left = gap_left - 1;
				in_valid <= 1'b0;
			end else if (query_queue.size() != 0 &&
			             !(query_queue[0].hold_off && inside_expected.size() != 0)) begin
				cur_query = query_queue.pop_front();
				point_x  <= cur_query.p.x;
				point_y  <= cur_query.p.y;
				point_z  <= cur_query.p.z;
				first_x  <= cur_query.a.x;
				first_y  <= cur_query.a.y;
				first_z  <= cur_query.a.z;
				second_x <= cur_query.b.x;
				second_y <= cur_query.b.y;
				second_z <= cur_query.b.z;
				third_x  <= cur_query.c.x;
				third_y  <= cur_query.c.y;
				third_z  <= cur_query.c.z;
				in_valid <= 1'b1;
				gap_left = quiet ? 0 : pick_gap();
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Check each accepted result against the oldest expectation; stall at random
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_stall <= 1'b0;
			stall_left = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (inside_expected.size() == 0) begin
					report_mismatch("result with no query pending", inside_res, 1'b0);
				end else begin
					want = inside_expected.pop_front();
					if (inside_res !== want)
						report_mismatch("wrong answer", inside_res, want);
				end
			end
			if (stall_left != 0)
				stall_left = stall_left - 1;
			else if (!quiet && $urandom_range(4) == 0)
				stall_left = pick_gap();
			out_stall <= (stall_left != 0);
		end
	end

	// Bound the run
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	initial begin
		query_t q;
		pt_t    lo, hi;
		lo = mk_pt(-32768, -32768, -32768);
		hi = mk_pt(32767, 32767, 32767);

		// plain triangle: inside, outside, on an edge, at a vertex, on an edge line
		add_query(mk_pt(10, 10, 0), mk_pt(0, 0, 0), mk_pt(100, 0, 0), mk_pt(0, 100, 0));
		add_query(mk_pt(200, 200, 0), mk_pt(0, 0, 0), mk_pt(100, 0, 0), mk_pt(0, 100, 0));
		add_query(mk_pt(50, 0, 0), mk_pt(0, 0, 0), mk_pt(100, 0, 0), mk_pt(0, 100, 0));
		add_query(mk_pt(50, 50, 0), mk_pt(0, 0, 0), mk_pt(100, 0, 0), mk_pt(0, 100, 0));
		add_query(mk_pt(0, 0, 0), mk_pt(0, 0, 0), mk_pt(100, 0, 0), mk_pt(0, 100, 0));
		add_query(mk_pt(200, 0, 0), mk_pt(0, 0, 0), mk_pt(100, 0, 0), mk_pt(0, 100, 0));
		add_query(mk_pt(-1, 10, 0), mk_pt(0, 0, 0), mk_pt(100, 0, 0), mk_pt(0, 100, 0));
		// point off the plane, above the interior and below the outside
		add_query(mk_pt(10, 10, 500), mk_pt(0, 0, 0), mk_pt(100, 0, 0), mk_pt(0, 100, 0));
		add_query(mk_pt(300, 10, -500), mk_pt(0, 0, 0), mk_pt(100, 0, 0), mk_pt(0, 100, 0));
		// degenerate triangles: one point, collinear vertices
		add_query(hi, mk_pt(5, 5, 5), mk_pt(5, 5, 5), mk_pt(5, 5, 5));
		add_query(mk_pt(7, -3, 1), mk_pt(0, 0, 0), mk_pt(10, 10, 10), mk_pt(-20, -20, -20));
		add_query(lo, lo, lo, lo);
		add_query(hi, hi, hi, hi);
		// extreme corners with the widest products
		add_query(lo, lo, mk_pt(32767, -32768, 32767), mk_pt(-32768, 32767, 32767));
		add_query(hi, lo, mk_pt(32767, -32768, 32767), mk_pt(-32768, 32767, 32767));
		add_query(mk_pt(0, 0, 0), lo, mk_pt(32767, -32768, 32767), mk_pt(-32768, 32767, 32767));
		add_query(lo, hi, mk_pt(-32768, 32767, -32768), mk_pt(32767, -32768, -32768));
		add_query(mk_pt(32767, -32768, 0), mk_pt(-32768, -32768, 0),
		          mk_pt(32767, 32767, 0), mk_pt(-32768, 32767, 0));
		add_query(mk_pt(-32768, 32767, 0), mk_pt(-32768, -32768, 0),
		          mk_pt(32767, 32767, 0), mk_pt(-32768, 32767, 0));
		// alternating bit patterns
		add_query(mk_pt(21845, -21846, 21845), mk_pt(-21846, 21845, -21846),
		          mk_pt(21845, 21845, -21846), mk_pt(-21846, -21846, 21845));
		add_query(mk_pt(-21846, 21845, -21846), mk_pt(21845, -21846, 21845),
		          mk_pt(-21846, -21846, 21845), mk_pt(21845, 21845, -21846));

		// random queries; now and then wait for the pipeline to drain first
		for (int i = 0; i < RANDOM_QUERIES; i++) begin
			q = make_random_query();
			q.hold_off = (i % 300 == 0);
			query_queue.push_back(q);
		end

		// reset once
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// wait for every query to be accepted and answered, then for the tail
		while (query_queue.size() != 0 || in_valid || inside_expected.size() != 0)
			@(negedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (mismatch_count == 0)
			$display("TEST PASSED");
		else
			$display("TEST FAILED");
		$finish;
	end

endmodule
